/* sv/ixpf_pkg.sv */
// Shared types and constants for the interleaved XOR parity FEC encoder.
`default_nettype none

package ixpf_pkg;

  localparam int SEQ_W  = 32;
  localparam int IDX_W  = 5;
  localparam int WORD_W = 64;
  localparam int GS_W   = 8;
  localparam int STR_W  = 5;
  localparam int CFG_W  = 8;

  // Sequence bits folded into the running remainder per cycle of the modulo unit.
  localparam int DIGIT_BITS = 8;
  localparam int DIGITS     = SEQ_W / DIGIT_BITS;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE     = 1'd1;

  localparam logic [GS_W-1:0]  GROUP_SIZE_RESET = 8'd2;
  localparam logic [STR_W-1:0] STRIDE_RESET     = 5'd1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_PARITY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_UPDATE,
    ST_SEND_DATA,
    ST_SEND_PARITY
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  frame_seq;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] payload_word;
    logic              frame_last;
  } word_t;

  typedef struct packed {
    logic              packet_kind;
    logic [SEQ_W-1:0]  seq_or_base;
    logic [IDX_W-1:0]  out_index;
    logic [WORD_W-1:0] out_word;
    logic              packet_end;
    logic              run_end;
  } result_t;

endpackage

`default_nettype wire

/* sv/ixpf_stream_if.sv */
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none

interface ixpf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/interleaved_xor_parity_fec_encoder.sv */
// Each input word passes the modulo, parity read and update states before the data
// word is offered; a parity word is offered the cycle after the data word is taken.
// A new input word is taken only once the last one and its parity are sent. The
// 32-bit modulo is folded 8 bits a cycle, one compare-subtract per bit, on one unit.
// Reset (rst, synchronous) clears phase bases and counts and restores the registers;
// the parity memory is not cleared, and its read value is used only for a nonzero count.
`default_nettype none

module interleaved_xor_parity_fec_encoder #(
  parameter int MAX_STRIDE      = 16,
  parameter int WORDS_PER_FRAME = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [ixpf_pkg::REG_IDX_W-1:0] wr_index,
  input  wire logic [ixpf_pkg::CFG_W-1:0]     wr_data,
  ixpf_stream_if.sink                        words,
  ixpf_stream_if.source                      results
);

  localparam int PH_W   = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int DEPTH  = MAX_STRIDE * WORDS_PER_FRAME;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ixpf_pkg::state_t state, state_next;

  logic [ixpf_pkg::GS_W-1:0]  group_size;
  logic [ixpf_pkg::STR_W-1:0] interleave_stride;

  logic [ixpf_pkg::SEQ_W-1:0]  seq;
  logic [ixpf_pkg::IDX_W-1:0]  idx;
  logic [ixpf_pkg::WORD_W-1:0] word;
  logic                        last;
  logic [ixpf_pkg::SEQ_W-1:0]  dividend;
  logic [ixpf_pkg::STR_W-1:0]  rem, rem_next;
  logic [ixpf_pkg::DIGIT_CNT_W-1:0] digit;

  logic [ixpf_pkg::SEQ_W-1:0] phase_base  [MAX_STRIDE];
  logic [ixpf_pkg::GS_W-1:0]  phase_count [MAX_STRIDE];

  logic [ixpf_pkg::WORD_W-1:0] parity_mem [DEPTH];
  logic [ixpf_pkg::WORD_W-1:0] parity_rd;

  logic                        emit;
  logic [ixpf_pkg::WORD_W-1:0] par;
  logic [ixpf_pkg::SEQ_W-1:0]  base;
  ixpf_pkg::result_t           out_reg;

  logic [ixpf_pkg::STR_W-1:0]  stride_eff;
  logic [PH_W-1:0]             phase;
  logic [ADDR_W-1:0]           addr;
  logic                        idx_ok;
  logic [ixpf_pkg::GS_W-1:0]   cnt;
  logic [ixpf_pkg::GS_W-1:0]   cnt_inc;
  logic                        full;
  logic                        emit_next;
  logic [ixpf_pkg::WORD_W-1:0] par_next;
  logic [ixpf_pkg::SEQ_W-1:0]  base_next;
  logic                        in_xfer;
  logic                        out_xfer;

  assign in_xfer  = words.valid & words.ready;
  assign out_xfer = results.valid & results.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_size        <= ixpf_pkg::GROUP_SIZE_RESET;
      interleave_stride <= ixpf_pkg::STRIDE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        ixpf_pkg::REG_GROUP_SIZE: group_size        <= wr_data[ixpf_pkg::GS_W-1:0];
        ixpf_pkg::REG_STRIDE:     interleave_stride <= wr_data[ixpf_pkg::STR_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero stride acts as one; a stride above the phase count saturates.
  always_comb begin
    if (interleave_stride == '0) begin
      stride_eff = ixpf_pkg::STR_W'(1);
    end else if (32'(interleave_stride) > MAX_STRIDE) begin
      stride_eff = ixpf_pkg::STR_W'(MAX_STRIDE);
    end else begin
      stride_eff = interleave_stride;
    end
  end

  // Shared modulo unit: folds one byte of the sequence into the remainder. The
  // remainder stays below the stride, so one compare-subtract per bit suffices.
  always_comb begin
    logic [ixpf_pkg::STR_W:0]   t;
    logic [ixpf_pkg::STR_W-1:0] r;
    r = rem;
    for (int b = 0; b < ixpf_pkg::DIGIT_BITS; b++) begin
      t = {r, dividend[ixpf_pkg::SEQ_W-1-b]};
      if (t >= {1'b0, stride_eff}) begin
        t = t - {1'b0, stride_eff};
      end
      r = t[ixpf_pkg::STR_W-1:0];
    end
    rem_next = r;
  end

  assign phase  = PH_W'(rem);
  assign idx_ok = 32'(idx) < WORDS_PER_FRAME;
  assign addr   = ADDR_W'(32'(phase) * WORDS_PER_FRAME + 32'(idx));

  // Group bookkeeping for the word being updated.
  always_comb begin
    cnt       = phase_count[phase];
    cnt_inc   = cnt + ixpf_pkg::GS_W'(1);
    full      = (cnt_inc == group_size);
    emit_next = idx_ok & full;
    par_next  = (cnt == '0) ? word : (parity_rd ^ word);
    base_next = (cnt == '0) ? seq : phase_base[phase];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ixpf_pkg::ST_IDLE: begin
        if (in_xfer) state_next = ixpf_pkg::ST_MOD;
      end
      ixpf_pkg::ST_MOD: begin
        if (digit == ixpf_pkg::DIGIT_CNT_W'(ixpf_pkg::DIGITS - 1)) begin
          state_next = ixpf_pkg::ST_READ;
        end
      end
      ixpf_pkg::ST_READ:   state_next = ixpf_pkg::ST_UPDATE;
      ixpf_pkg::ST_UPDATE: state_next = ixpf_pkg::ST_SEND_DATA;
      ixpf_pkg::ST_SEND_DATA: begin
        if (out_xfer) state_next = emit ? ixpf_pkg::ST_SEND_PARITY : ixpf_pkg::ST_IDLE;
      end
      ixpf_pkg::ST_SEND_PARITY: begin
        if (out_xfer) state_next = ixpf_pkg::ST_IDLE;
      end
      default: state_next = ixpf_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    words.ready   = (state == ixpf_pkg::ST_IDLE);
    results.valid = (state == ixpf_pkg::ST_SEND_DATA) || (state == ixpf_pkg::ST_SEND_PARITY);
    results.data  = out_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ixpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers and modulo iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      digit <= '0;
    end else if (in_xfer) begin
      digit <= '0;
    end else if (state == ixpf_pkg::ST_MOD) begin
      digit <= digit + ixpf_pkg::DIGIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      seq      <= words.data.frame_seq;
      idx      <= words.data.word_index;
      word     <= words.data.payload_word;
      last     <= words.data.frame_last;
      dividend <= words.data.frame_seq;
      rem      <= '0;
    end else if (state == ixpf_pkg::ST_MOD) begin
      dividend <= dividend << ixpf_pkg::DIGIT_BITS;
      rem      <= rem_next;
    end
  end

  // Phase bases and member counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < MAX_STRIDE; p++) begin
        phase_base[p]  <= '0;
        phase_count[p] <= '0;
      end
    end else if (state == ixpf_pkg::ST_UPDATE) begin
      phase_base[phase] <= base_next;
      if (last) begin
        phase_count[phase] <= full ? '0 : cnt_inc;
      end
    end
  end

  // Parity memory: one read port for the READ state, one write in UPDATE.
  always_ff @(posedge clk) begin
    if (state == ixpf_pkg::ST_READ) begin
      parity_rd <= parity_mem[addr];
    end
    if ((state == ixpf_pkg::ST_UPDATE) && idx_ok) begin
      parity_mem[addr] <= par_next;
    end
  end

  // Output register: the data word first, then the parity word if one is due.
  always_ff @(posedge clk) begin
    if (state == ixpf_pkg::ST_UPDATE) begin
      emit                <= emit_next;
      par                 <= par_next;
      base                <= base_next;
      out_reg.packet_kind <= ixpf_pkg::KIND_DATA;
      out_reg.seq_or_base <= seq;
      out_reg.out_index   <= idx;
      out_reg.out_word    <= word;
      out_reg.packet_end  <= last;
      out_reg.run_end     <= ~emit_next;
    end else if ((state == ixpf_pkg::ST_SEND_DATA) && out_xfer && emit) begin
      out_reg.packet_kind <= ixpf_pkg::KIND_PARITY;
      out_reg.seq_or_base <= base;
      out_reg.out_word    <= par;
      out_reg.run_end     <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* sv/ixpf_checker.sv */
// Port-level assertions for the encoder, bound to the top level.
`default_nettype none

module ixpf_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire ixpf_pkg::result_t out_data
);

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");

  a_no_input_while_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_parity_follows_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (out_data.packet_kind == ixpf_pkg::KIND_DATA) &&
    !out_data.run_end |=> out_valid && (out_data.packet_kind == ixpf_pkg::KIND_PARITY))
    else $error("parity word missing after data word");

  a_parity_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.packet_kind == ixpf_pkg::KIND_PARITY) |-> out_data.run_end)
    else $error("parity word not marked as last of its run");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind interleaved_xor_parity_fec_encoder ixpf_checker u_ixpf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (words.valid),
  .in_ready  (words.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);

`default_nettype wire
